FILE: sv/replay_nonce_table_assert.svh
`ifndef REPLAY_NONCE_TABLE_ASSERT_SVH
`define REPLAY_NONCE_TABLE_ASSERT_SVH

// concurrent check on an explicit clock and active-low reset
`define RNT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("replay_nonce_table: assertion failed");

// same check on the block clock and reset
`define RNT_ASSERT_BLK(label, prop) \
    `RNT_ASSERT(label, i_clk, i_rst_n, prop)

`endif

FILE: sv/rnt_pkg.sv
package rnt_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 64;

    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int IN_KEY_W   = 64;
    localparam int TIME_W     = 32;
    localparam int TTL_W      = 31;
    localparam int MP_W       = 6;
    localparam int OCC_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int SLOT_W     = KEY_BITS + TIME_W;
    localparam int CMP_W      = (CNT_W > MP_W) ? CNT_W : MP_W;
    localparam int MAX_OCC    = (ENTRIES > 127) ? 127 : ENTRIES;

    // 4/5 as 820/1024, exact over the register range
    localparam int KEEP_MUL   = 820;
    localparam int KEEP_SHIFT = 10;

    typedef logic [STATUS_W-1:0] t_status;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_COLLECT = 1'b1;

    localparam t_status ST_INSERTED  = 2'd0;
    localparam t_status ST_REPLAY    = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_COLLECTED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TTL        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = 1'b1;

    // floor(4*mp/5)
    function automatic logic [MP_W-1:0] keep_level(input logic [MP_W-1:0] mp);
        logic [MP_W+KEEP_SHIFT-1:0] prod;
        prod = (MP_W + KEEP_SHIFT)'(mp) * (MP_W + KEEP_SHIFT)'(KEEP_MUL);
        return prod[MP_W+KEEP_SHIFT-1:KEEP_SHIFT];
    endfunction

endpackage

FILE: sv/rnt_ram.sv
module rnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/replay_nonce_table.sv
// replay_nonce_table: anti-replay nonce cache with a time-to-live. Each transaction on the
// input channel is an insert (command 0) or a collection (command 1) and yields exactly one
// result transaction with a status and the occupancy after the operation. Keys and arrival
// stamps live in a single-port-read slot RAM with registered read, valid bits in flip-flops;
// all work is done by one age/compare unit that walks the slots one per cycle. A collection
// runs one expiry pass and a plain insert one replay pass. An insert that finds occupancy
// above the fill limit first runs an expiry pass and then one oldest-entry pass per evicted
// entry before the replay pass. One transaction is in flight at a time; o_in_stall is high
// while it is worked on and while its result waits for a stalled output register, and a
// finished result waits in the output register while the next transaction is taken.
// Occupancy over the fill limit prunes down to floor(4*limit/5); ages are (now - stamp)
// mod 2^32. Configuration writes (ttl at index 0, fill limit at index 1) belong only in
// idle periods.
module replay_nonce_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rnt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rnt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [rnt_pkg::IN_KEY_W-1:0]    i_key,
    input  logic [rnt_pkg::TIME_W-1:0]      i_now,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rnt_pkg::STATUS_W-1:0]    o_status,
    output logic [rnt_pkg::OCC_W-1:0]       o_occupancy
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPIRE = 3'd1;
    localparam logic [2:0] S_OLDEST = 3'd2;
    localparam logic [2:0] S_MATCH  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam int IDX_W  = rnt_pkg::IDX_W;
    localparam int ADDR_W = rnt_pkg::ADDR_W;
    localparam int CNT_W  = rnt_pkg::CNT_W;
    localparam int CMP_W  = rnt_pkg::CMP_W;
    localparam int TIME_W = rnt_pkg::TIME_W;

    // control state
    logic [2:0]                       r_state, n_state;
    logic [rnt_pkg::TTL_W-1:0]        r_ttl, n_ttl;
    logic [rnt_pkg::MP_W-1:0]         r_fill_limit, n_fill_limit;
    logic [rnt_pkg::ENTRIES-1:0]      r_valid, n_valid;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic                             r_cmp_vld, n_cmp_vld;
    logic                             r_out_vld, n_out_vld;

    // transaction and scan payload
    logic                             r_cmd, n_cmd;
    logic [rnt_pkg::KEY_BITS-1:0]     r_key, n_key;
    logic [TIME_W-1:0]                r_now, n_now;
    logic [ADDR_W-1:0]                r_addr, n_addr;
    logic [IDX_W-1:0]                 r_cmp_idx, n_cmp_idx;
    logic                             r_found, n_found;
    logic [TIME_W-1:0]                r_best_age, n_best_age;
    logic [IDX_W-1:0]                 r_best_idx, n_best_idx;
    logic                             r_hit, n_hit;
    logic                             r_free_found, n_free_found;
    logic [IDX_W-1:0]                 r_free_idx, n_free_idx;
    logic [rnt_pkg::STATUS_W-1:0]     r_result, n_result;
    logic [rnt_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic [rnt_pkg::OCC_W-1:0]        r_out_occ, n_out_occ;

    // slot ram
    logic                             ram_wr_en;
    logic [IDX_W-1:0]                 ram_wr_addr;
    logic [rnt_pkg::SLOT_W-1:0]       ram_wr_data;
    logic [rnt_pkg::SLOT_W-1:0]       ram_rd_data;

    // shared age/compare unit
    logic [TIME_W-1:0]                rd_stamp;
    logic [rnt_pkg::KEY_BITS-1:0]     rd_key;
    logic [TIME_W-1:0]                age;
    logic                             cur_valid;
    logic                             is_expired;
    logic                             is_older;
    logic                             is_hit;
    logic                             is_free;
    logic                             pass_end;
    logic [CMP_W-1:0]                 keep_cmp;
    logic [CMP_W-1:0]                 mp_cmp;

    rnt_ram #(
        .WIDTH (rnt_pkg::SLOT_W),
        .DEPTH (rnt_pkg::ENTRIES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // slot word: key above stamp
    assign rd_stamp   = ram_rd_data[TIME_W-1:0];
    assign rd_key     = ram_rd_data[rnt_pkg::SLOT_W-1:TIME_W];

    // wrapping age of the slot whose data came back this cycle
    assign age        = r_now - rd_stamp;
    assign cur_valid  = r_cmp_vld && r_valid[r_cmp_idx];
    assign is_expired = cur_valid && (age > TIME_W'(r_ttl));
    // strictly older keeps the lowest slot on ties
    assign is_older   = cur_valid && (!r_found || (age > r_best_age));
    assign is_hit     = cur_valid && (rd_key == r_key);
    assign is_free    = r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found;
    assign pass_end   = r_cmp_vld && (r_cmp_idx == IDX_W'(rnt_pkg::ENTRIES - 1));

    assign keep_cmp   = CMP_W'(rnt_pkg::keep_level(r_fill_limit));
    assign mp_cmp     = CMP_W'(r_fill_limit);

    always_comb begin
        n_state       = r_state;
        n_ttl         = r_ttl;
        n_fill_limit  = r_fill_limit;
        n_valid       = r_valid;
        n_count       = r_count;
        n_cmp_vld     = r_cmp_vld;
        n_out_vld     = r_out_vld;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_now         = r_now;
        n_addr        = r_addr;
        n_cmp_idx     = r_cmp_idx;
        n_found       = r_found;
        n_best_age    = r_best_age;
        n_best_idx    = r_best_idx;
        n_hit         = r_hit;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_result      = r_result;
        n_out_status  = r_out_status;
        n_out_occ     = r_out_occ;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = r_free_idx;
        ram_wr_data   = {r_key, r_now};

        // config writes: the user must issue them only while idle; the block does not enforce it
        if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                rnt_pkg::CFG_TTL:        n_ttl = i_cfg_wdata[rnt_pkg::TTL_W-1:0];
                rnt_pkg::CFG_FILL_LIMIT: n_fill_limit = i_cfg_wdata[rnt_pkg::MP_W-1:0];
                default:                 n_ttl = r_ttl;
            endcase
        end

        // result leaves the output register
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        // slot walker: issue one read a cycle, compare in the following cycle
        if (r_state == S_EXPIRE || r_state == S_OLDEST || r_state == S_MATCH) begin
            if (r_addr < ADDR_W'(rnt_pkg::ENTRIES)) begin
                n_addr    = r_addr + ADDR_W'(1);
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_addr[IDX_W-1:0];
            end else begin
                n_cmp_vld = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_command;
                    n_key        = i_key[rnt_pkg::KEY_BITS-1:0];
                    n_now        = i_now;
                    n_addr       = '0;
                    n_cmp_vld    = 1'b0;
                    n_found      = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    // a collection always expires; an insert prunes only when over the pending limit
                    if (i_command == rnt_pkg::CMD_COLLECT ||
                        CMP_W'(r_count) > mp_cmp) begin
                        n_state = S_EXPIRE;
                    end else begin
                        n_state = S_MATCH;
                    end
                end
            end

            S_EXPIRE: begin
                if (is_expired) begin
                    n_valid[r_cmp_idx] = 1'b0;
                    n_count            = r_count - CNT_W'(1);
                end
                if (pass_end) begin
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                    n_found   = 1'b0;
                    priority if (r_cmd == rnt_pkg::CMD_COLLECT) begin
                        n_result = rnt_pkg::ST_COLLECTED;
                        n_state  = S_DONE;
                    end else if (CMP_W'(n_count) > keep_cmp) begin
                        n_state = S_OLDEST;
                    end else if (CMP_W'(n_count) > mp_cmp) begin
                        n_result = rnt_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MATCH;
                    end
                end
            end

            S_OLDEST: begin
                if (is_older) begin
                    n_found    = 1'b1;
                    n_best_age = age;
                    n_best_idx = r_cmp_idx;
                end
                if (pass_end) begin
                    // evict the oldest entry, then decide whether another pass is due
                    if (n_found) begin
                        n_valid[n_best_idx] = 1'b0;
                        n_count             = r_count - CNT_W'(1);
                    end
                    priority if (n_found && CMP_W'(n_count) > keep_cmp) begin
                        n_state = S_OLDEST;
                    end else if (CMP_W'(n_count) > mp_cmp) begin
                        n_result = rnt_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MATCH;
                    end
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                    n_found   = 1'b0;
                end
            end

            S_MATCH: begin
                if (is_hit) begin
                    n_hit = 1'b1;
                end
                if (is_free) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (pass_end) begin
                    n_state = S_DONE;
                    priority if (n_hit) begin
                        n_result = rnt_pkg::ST_REPLAY;
                    end else if (n_free_found) begin
                        // store into the lowest free slot
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = n_free_idx;
                        n_valid[n_free_idx] = 1'b1;
                        n_count             = r_count + CNT_W'(1);
                        n_result            = rnt_pkg::ST_INSERTED;
                    end else begin
                        n_result = rnt_pkg::ST_FULL;
                    end
                end
            end

            S_DONE: begin
                // hand off once the output register is free or draining
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_result;
                    n_out_occ    = rnt_pkg::OCC_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ttl         <= rnt_pkg::TTL_W'(30);
            r_fill_limit  <= rnt_pkg::MP_W'(63);
            r_valid       <= '0;
            r_count       <= '0;
            r_cmp_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_ttl         <= n_ttl;
            r_fill_limit  <= n_fill_limit;
            r_valid       <= n_valid;
            r_count       <= n_count;
            r_cmp_vld     <= n_cmp_vld;
            r_out_vld     <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_now        <= n_now;
        r_addr       <= n_addr;
        r_cmp_idx    <= n_cmp_idx;
        r_found      <= n_found;
        r_best_age   <= n_best_age;
        r_best_idx   <= n_best_idx;
        r_hit        <= n_hit;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_result     <= n_result;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    // ready only between transactions
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

endmodule

FILE: sv/rnt_checker.sv
`include "replay_nonce_table_assert.svh"

module rnt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_wr_en,
    input logic [rnt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [rnt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_command,
    input logic [rnt_pkg::IN_KEY_W-1:0]    i_key,
    input logic [rnt_pkg::TIME_W-1:0]      i_now,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [rnt_pkg::STATUS_W-1:0]    o_status,
    input logic [rnt_pkg::OCC_W-1:0]       o_occupancy
);

    // a taken transaction keeps the block busy on the next cycle
    `RNT_ASSERT_BLK(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall)

    // a new result only comes out of a busy period
    `RNT_ASSERT_BLK(a_result_after_work, $rose(o_out_valid) |-> $past(o_in_stall))

    // occupancy never exceeds the table size
    `RNT_ASSERT_BLK(a_occ_bound, o_out_valid |-> (o_occupancy <= rnt_pkg::OCC_W'(rnt_pkg::MAX_OCC)))

    // a stalled result stays offered
    `RNT_ASSERT_BLK(a_out_hold, $past(o_out_valid && i_out_stall) |-> o_out_valid)

endmodule

bind replay_nonce_table rnt_checker u_rnt_checker (.*);

FILE: bench/replay_nonce_table_check.sv
module replay_nonce_table_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rnt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rnt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_command,
    input  logic [rnt_pkg::IN_KEY_W-1:0]   i_key,
    input  logic [rnt_pkg::TIME_W-1:0]     i_now,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [rnt_pkg::STATUS_W-1:0]   i_status,
    input  logic [rnt_pkg::OCC_W-1:0]      i_occupancy,
    output int                             o_pending,
    output int                             o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        rnt_pkg::t_status          status;
        logic [rnt_pkg::OCC_W-1:0] occupancy;
    } t_outcome;

    // shadow copy of the nonce store
    logic                         nonce_live [rnt_pkg::ENTRIES];
    logic [rnt_pkg::KEY_BITS-1:0] nonce_key  [rnt_pkg::ENTRIES];
    logic [rnt_pkg::TIME_W-1:0]   nonce_seen [rnt_pkg::ENTRIES];
    int                           live_count;
    logic [rnt_pkg::TTL_W-1:0]    ttl_cfg;
    logic [rnt_pkg::MP_W-1:0]     pending_cap;

    t_outcome awaited_outcomes[$];
    int       fails = 0;

    assign o_fail_count = fails;

    initial o_pending = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: replay_nonce_table mismatch: %s", $time, msg);
        fails++;
    endtask

    function automatic void purge_expired(input logic [rnt_pkg::TIME_W-1:0] t);
        logic [rnt_pkg::TIME_W-1:0] age;
        for (int s = 0; s < rnt_pkg::ENTRIES; s++) begin
            age = t - nonce_seen[s];
            if (nonce_live[s] && age > {1'b0, ttl_cfg}) begin
                nonce_live[s] = 1'b0;
                live_count--;
            end
        end
    endfunction

    // greatest age goes first, lowest slot wins a tie
    function automatic void evict_oldest(input int keep, input logic [rnt_pkg::TIME_W-1:0] t);
        logic [rnt_pkg::TIME_W-1:0] age;
        logic [rnt_pkg::TIME_W-1:0] oldest;
        int                         pick;
        while (live_count > keep) begin
            pick = -1;
            oldest = '0;
            for (int s = 0; s < rnt_pkg::ENTRIES; s++) begin
                age = t - nonce_seen[s];
                if (nonce_live[s] && (pick < 0 || age > oldest)) begin
                    pick = s;
                    oldest = age;
                end
            end
            if (pick < 0)
                break;
            nonce_live[pick] = 1'b0;
            live_count--;
        end
    endfunction

    function automatic rnt_pkg::t_status admit_nonce(input logic [rnt_pkg::KEY_BITS-1:0] k,
                                                     input logic [rnt_pkg::TIME_W-1:0] t);
        int keep;
        if (live_count > int'(pending_cap)) begin
            keep = (int'(pending_cap) * 4) / 5;
            purge_expired(t);
            if (live_count > keep)
                evict_oldest(keep, t);
            if (live_count > int'(pending_cap))
                return rnt_pkg::ST_FULL;
        end
        for (int s = 0; s < rnt_pkg::ENTRIES; s++) begin
            if (nonce_live[s] && nonce_key[s] == k)
                return rnt_pkg::ST_REPLAY;
        end
        for (int s = 0; s < rnt_pkg::ENTRIES; s++) begin
            if (!nonce_live[s]) begin
                nonce_live[s] = 1'b1;
                nonce_key[s] = k;
                nonce_seen[s] = t;
                live_count++;
                return rnt_pkg::ST_INSERTED;
            end
        end
        return rnt_pkg::ST_FULL;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome oldest_want;
        if (!i_rst_n) begin
            ttl_cfg = rnt_pkg::TTL_W'(30);
            pending_cap = rnt_pkg::MP_W'(63);
            for (int s = 0; s < rnt_pkg::ENTRIES; s++) begin
                nonce_live[s] = 1'b0;
                nonce_key[s] = '0;
                nonce_seen[s] = '0;
            end
            live_count = 0;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    rnt_pkg::CFG_TTL:        ttl_cfg = i_cfg_wdata[rnt_pkg::TTL_W-1:0];
                    rnt_pkg::CFG_FILL_LIMIT: pending_cap = i_cfg_wdata[rnt_pkg::MP_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a stray result never meets a fresh expectation
            if (i_out_valid && !i_out_stall) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result status %0d occupancy %0d with none awaited",
                                              i_status, i_occupancy));
                end else begin
                    oldest_want = awaited_outcomes.pop_front();
                    if (i_status !== oldest_want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, oldest_want.status));
                    if (i_occupancy !== oldest_want.occupancy)
                        report_mismatch($sformatf("occupancy got %0d want %0d",
                                                  i_occupancy, oldest_want.occupancy));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == rnt_pkg::CMD_INSERT) begin
                    want.status = admit_nonce(i_key[rnt_pkg::KEY_BITS-1:0], i_now);
                end else begin
                    purge_expired(i_now);
                    want.status = rnt_pkg::ST_COLLECTED;
                end
                want.occupancy = rnt_pkg::OCC_W'(live_count);
                awaited_outcomes.push_back(want);
            end
        end
        o_pending <= awaited_outcomes.size();
    end

endmodule

FILE: bench/replay_nonce_table_test.sv
module replay_nonce_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    // every input starts known
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rnt_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [rnt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           in_valid = 1'b0;
    logic                           command = rnt_pkg::CMD_INSERT;
    logic [rnt_pkg::IN_KEY_W-1:0]   key = '0;
    logic [rnt_pkg::TIME_W-1:0]     now = '0;
    logic                           out_stall = 1'b0;

    logic                           in_stall;
    logic                           out_valid;
    logic [rnt_pkg::STATUS_W-1:0]   status;
    logic [rnt_pkg::OCC_W-1:0]      occupancy;

    int pending;
    int fail_count;

    // sender burst bookkeeping and receiver stall pattern state
    int burst_left = 3;
    int stall_run = 0;
    int stall_mode = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    replay_nonce_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_command   (command),
        .i_key       (key),
        .i_now       (now),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_occupancy (occupancy)
    );

    replay_nonce_table_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_command    (command),
        .i_key        (key),
        .i_now        (now),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_occupancy  (occupancy),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // receiver: modes last a random stretch; free flow, light, heavy, and long stall runs
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(20, 200);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ((stall_run % 16) < 10);
        endcase
    end

    // one transaction on the input channel; payload holds while stalled
    task automatic send_item(input logic cmd, input logic [rnt_pkg::IN_KEY_W-1:0] k,
                             input logic [rnt_pkg::TIME_W-1:0] t);
        int gap;
        in_valid <= 1'b1;
        command <= cmd;
        key <= k;
        now <= t;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        burst_left--;
        // end of burst: drop valid for a random gap, then pick the next burst size
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge i_clk);
        end
    endtask

    // every transaction yields a result, so an empty expectation store means idle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rnt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rnt_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [rnt_pkg::TTL_W-1:0]    ttl_v;
        logic [rnt_pkg::MP_W-1:0]     mp_v;
        logic [rnt_pkg::TIME_W-1:0]   clock_t;
        logic [rnt_pkg::TIME_W-1:0]   step_max;
        logic [rnt_pkg::IN_KEY_W-1:0] key_pool [96];
        logic [rnt_pkg::IN_KEY_W-1:0] k;
        logic [rnt_pkg::IN_KEY_W-1:0] last_k;
        int                           pool_size;
        int                           r;

        repeat (7)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults ttl 30, fill limit 63
        write_reg(rnt_pkg::CFG_TTL, rnt_pkg::CFG_DATA_W'(30));
        write_reg(rnt_pkg::CFG_FILL_LIMIT, rnt_pkg::CFG_DATA_W'(63));
        send_item(rnt_pkg::CMD_INSERT, '0, 32'd0);
        send_item(rnt_pkg::CMD_INSERT, '1, 32'd1);
        send_item(rnt_pkg::CMD_INSERT, '0, 32'd2);                    // replay of key zero
        send_item(rnt_pkg::CMD_COLLECT, '1, 32'd5);                   // nothing old enough yet
        send_item(rnt_pkg::CMD_COLLECT, '0, 32'hFFFF_FFFF);           // huge age, both go
        send_item(rnt_pkg::CMD_INSERT, {32{2'b01}}, 32'hFFFF_FFF0);
        send_item(rnt_pkg::CMD_COLLECT, '1, 32'h0000_0005);           // age across the wrap is 21
        send_item(rnt_pkg::CMD_INSERT, {32{2'b01}}, 32'h0000_000E);   // age exactly ttl still counts
        send_item(rnt_pkg::CMD_COLLECT, '0, 32'h0000_000F);           // age ttl+1 expires

        // directed: widest ttl, tiny cap so pruning kicks in on equal stamps
        write_reg(rnt_pkg::CFG_TTL, rnt_pkg::CFG_DATA_W'(31'h7FFF_FFFF));
        write_reg(rnt_pkg::CFG_FILL_LIMIT, rnt_pkg::CFG_DATA_W'(2));
        send_item(rnt_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF, 32'd100);
        send_item(rnt_pkg::CMD_INSERT, 64'hFEDC_BA98_7654_3210, 32'd100);
        send_item(rnt_pkg::CMD_INSERT, 64'h8000_0000_0000_0001, 32'd100);
        // tie on age drops the two lowest slots, own key among them, so it goes back in
        send_item(rnt_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF, 32'd100);
        send_item(rnt_pkg::CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 32'h8000_0064);
        // age 2^31 expires
        send_item(rnt_pkg::CMD_COLLECT, 64'h5A5A_5A5A_5A5A_5A5A, 32'h8000_0064);

        // directed: zero ttl and zero cap, every insert into a non-empty table prunes everything first
        write_reg(rnt_pkg::CFG_TTL, rnt_pkg::CFG_DATA_W'(0));
        write_reg(rnt_pkg::CFG_FILL_LIMIT, rnt_pkg::CFG_DATA_W'(0));
        send_item(rnt_pkg::CMD_INSERT, 64'hDEAD_BEEF_CAFE_F00D, 32'd7);
        send_item(rnt_pkg::CMD_INSERT, 64'hDEAD_BEEF_CAFE_F00D, 32'd7);   // evicted, accepted again
        send_item(rnt_pkg::CMD_COLLECT, {$urandom, $urandom}, 32'd7);
        send_item(rnt_pkg::CMD_COLLECT, {$urandom, $urandom}, 32'd8);

        // random phases, each with its own settings and a fresh key pool
        last_k = '0;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    ttl_v = 31'h7FFF_FFFF;
                    mp_v = 6'd63;
                    step_max = 32'd3;
                    pool_size = 96;
                end
                1: begin
                    ttl_v = '0;
                    mp_v = '0;
                    step_max = 32'd1;
                    pool_size = 8;
                end
                2: begin
                    ttl_v = 31'd40;
                    mp_v = 6'd63;
                    step_max = 32'd2;
                    pool_size = 96;
                end
                3: begin
                    ttl_v = rnt_pkg::TTL_W'($urandom_range(1, 200));
                    mp_v = rnt_pkg::MP_W'($urandom_range(0, 63));
                    step_max = rnt_pkg::TIME_W'(ttl_v / 8 + 1);
                    pool_size = $urandom_range(16, 96);
                end
                4: begin
                    ttl_v = rnt_pkg::TTL_W'($urandom);
                    mp_v = 6'd10;
                    step_max = 32'h4000_0000;
                    pool_size = 24;
                end
                default: begin
                    ttl_v = 31'd20;
                    mp_v = 6'd5;
                    step_max = 32'd3;
                    pool_size = 12;
                end
            endcase
            write_reg(rnt_pkg::CFG_TTL, rnt_pkg::CFG_DATA_W'(ttl_v));
            // junk in the unused upper data bits must not matter
            write_reg(rnt_pkg::CFG_FILL_LIMIT,
                      (rnt_pkg::CFG_DATA_W'($urandom) & ~rnt_pkg::CFG_DATA_W'(6'h3F)) |
                      rnt_pkg::CFG_DATA_W'(mp_v));

            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int i = 2; i < 96; i++)
                key_pool[i] = {$urandom, $urandom};
            clock_t = $urandom;

            for (int n = 0; n < 92; n++) begin
                clock_t += $urandom_range(0, step_max);
                // rare long jump in time, wrap included
                if ($urandom_range(0, 39) == 0)
                    clock_t += $urandom;
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    send_item(rnt_pkg::CMD_COLLECT, {$urandom, $urandom}, clock_t);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 78)
                        k = key_pool[$urandom_range(0, pool_size - 1)];
                    else if (r < 90)
                        k = last_k;
                    else
                        k = {$urandom, $urandom};
                    last_k = k;
                    send_item(rnt_pkg::CMD_INSERT, k, clock_t);
                end
            end
        end

        // drain, then give any stray result time to show up
        wait_idle();
        repeat (100)
            @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS replay_nonce_table");
        else
            $display("FAIL replay_nonce_table");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #100_000_000;
        $display("FAIL replay_nonce_table");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/rnt_pkg.sv
sv/rnt_ram.sv
sv/replay_nonce_table.sv
sv/rnt_checker.sv
bench/replay_nonce_table_check.sv
bench/replay_nonce_table_test.sv
